// ===== src/lrl_pkg.sv =====
// shared types, constants and codes for the log burst rate limiter
package lrl_pkg;

    localparam int RING_DEPTH  = 16;
    localparam int RING_PTR_W  = (RING_DEPTH > 1) ? $clog2(RING_DEPTH) : 1;
    localparam int RING_CNT_W  = $clog2(RING_DEPTH + 1);
    localparam int STAMP_W     = 64;
    localparam int SCALE_SHIFT = 10;
    localparam int SCALED_W    = STAMP_W - SCALE_SHIFT;
    localparam int SKIP_W      = 32;
    localparam int TAG_W       = 8;
    localparam int VERDICT_W   = 3;
    localparam int CFG_INDEX_W = 2;
    localparam int CFG_DATA_W  = 64;

    localparam logic [SKIP_W-1:0] SKIP_MAX = {SKIP_W{1'b1}};

    localparam logic [CFG_INDEX_W-1:0] CFG_WINDOW_THRESHOLD = 2'd0;
    localparam logic [CFG_INDEX_W-1:0] CFG_RESUME_GAP       = 2'd1;
    localparam logic [CFG_INDEX_W-1:0] CFG_OUTPUT_DISABLED  = 2'd2;
    localparam logic [CFG_INDEX_W-1:0] CFG_SOURCE_TAG       = 2'd3;

    typedef enum logic [VERDICT_W-1:0] {
        V_PASS     = 3'd0,
        V_RESUME   = 3'd1,
        V_START    = 3'd2,
        V_SKIPPED  = 3'd3,
        V_DISABLED = 3'd4
    } verdict_t;

    typedef struct packed {
        logic [STAMP_W-1:0] window_threshold;
        logic [STAMP_W-1:0] resume_gap;
        logic               output_disabled;
        logic [TAG_W-1:0]   source_tag;
    } cfg_t;

    typedef struct packed {
        logic               push;
        logic               clear;
        logic [STAMP_W-1:0] stamp;
    } ring_cmd_t;

    typedef struct packed {
        logic               full;
        logic [STAMP_W-1:0] oldest;
        logic [STAMP_W-1:0] last;
    } ring_status_t;

    typedef struct packed {
        verdict_t            verdict;
        logic [SKIP_W-1:0]   skipped_count;
        logic                delta_negative;
        logic [SCALED_W-1:0] delta_magnitude;
        logic [TAG_W-1:0]    tag;
    } result_t;

endpackage

// ===== src/log_burst_rate_limiter_top.sv =====
// top level of the log burst rate limiter
//
//  channel   direction  handshake            payload
//  input     in         in_valid / in_stall  timestamp
//  result    out        out_valid/ out_stall verdict, skipped_count, delta_negative,
//                                            delta_magnitude, tag
//  config    in         cfg_we               cfg_index, cfg_data
//
// one item per cycle sustained while out_stall is low: an item is held in the input register,
// the decision and the ring update happen on the edge into the result register,
// so each item's decision sees the ring state left by the item before it
// rst_n clears control state, pointers and counters; ring entries stay unwritten
// a stalled result holds in the output register while the input register still
// takes one more item; only then does in_stall rise
module log_burst_rate_limiter_top (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            in_valid,
    output logic                            in_stall,
    input  logic [lrl_pkg::STAMP_W-1:0]     timestamp,
    output logic                            out_valid,
    input  logic                            out_stall,
    output logic [lrl_pkg::VERDICT_W-1:0]   verdict,
    output logic [lrl_pkg::SKIP_W-1:0]      skipped_count,
    output logic                            delta_negative,
    output logic [lrl_pkg::SCALED_W-1:0]    delta_magnitude,
    output logic [lrl_pkg::TAG_W-1:0]       tag,
    input  logic                            cfg_we,
    input  logic [lrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lrl_pkg::CFG_DATA_W-1:0]  cfg_data
);
    import lrl_pkg::*;

    // input register
    logic               in_valid_reg, in_valid_next;
    logic [STAMP_W-1:0] in_stamp_reg;

    // result register
    logic    out_valid_reg, out_valid_next;
    result_t out_result_reg;

    cfg_t         cfg;
    ring_cmd_t    ring_cmd;
    ring_status_t ring_status;
    result_t      result;

    logic in_accept;
    logic advance;

    // the held item moves on when the result register is free or being drained
    assign advance   = in_valid_reg && (!out_valid_reg || !out_stall);
    assign in_stall  = in_valid_reg && !advance;
    assign in_accept = in_valid && !in_stall;

    lrl_cfg u_cfg (
        .clk       (clk),
        .rst_n     (rst_n),
        .cfg_we    (cfg_we),
        .cfg_index (cfg_index),
        .cfg_data  (cfg_data),
        .cfg       (cfg)
    );

    lrl_ring u_ring (
        .clk    (clk),
        .rst_n  (rst_n),
        .cmd    (ring_cmd),
        .status (ring_status)
    );

    lrl_limiter u_limiter (
        .clk      (clk),
        .rst_n    (rst_n),
        .fire     (advance),
        .stamp    (in_stamp_reg),
        .cfg      (cfg),
        .ring     (ring_status),
        .ring_cmd (ring_cmd),
        .result   (result)
    );

    always_comb
    begin
        if (in_accept)
            in_valid_next = 1'b1;
        else if (advance)
            in_valid_next = 1'b0;
        else
            in_valid_next = in_valid_reg;

        if (advance)
            out_valid_next = 1'b1;
        else if (!out_stall)
            out_valid_next = 1'b0;
        else
            out_valid_next = out_valid_reg;
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg  <= 1'b0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            in_valid_reg  <= in_valid_next;
            out_valid_reg <= out_valid_next;
        end
    end

    // payload registers, no reset
    always_ff @(posedge clk)
    begin
        if (in_accept)
            in_stamp_reg <= timestamp;
        if (advance)
            out_result_reg <= result;
    end

    assign out_valid       = out_valid_reg;
    assign verdict         = out_result_reg.verdict;
    assign skipped_count   = out_result_reg.skipped_count;
    assign delta_negative  = out_result_reg.delta_negative;
    assign delta_magnitude = out_result_reg.delta_magnitude;
    assign tag             = out_result_reg.tag;

    // stall is only raised while an item is held and cannot move on
    a_stall_needs_item: assert property (@(posedge clk) disable iff (!rst_n)
        in_stall |-> (in_valid_reg && out_valid_reg && out_stall))
        else $error("input stalled without a blocked item");

    // ring is only touched by an item that actually moves on
    a_push_on_advance: assert property (@(posedge clk) disable iff (!rst_n)
        (ring_cmd.push || ring_cmd.clear) |-> advance)
        else $error("ring updated without an item");

    // skip count is reported only on a resume, and then it is nonzero
    a_skip_count_resume: assert property (@(posedge clk) disable iff (!rst_n)
        out_valid_reg |-> ((out_result_reg.verdict == V_RESUME) ==
                           (out_result_reg.skipped_count != '0)))
        else $error("skip count inconsistent with verdict");

    // dropped items carry no tag or delta
    a_drop_fields_zero: assert property (@(posedge clk) disable iff (!rst_n)
        (out_valid_reg && (out_result_reg.verdict == V_START ||
                           out_result_reg.verdict == V_SKIPPED ||
                           out_result_reg.verdict == V_DISABLED))
        |-> (out_result_reg.tag == '0 && out_result_reg.delta_magnitude == '0 &&
             !out_result_reg.delta_negative))
        else $error("dropped item carries payload");

    // a result that advances replaces the register the next cycle
    a_result_loaded: assert property (@(posedge clk) disable iff (!rst_n)
        advance |=> out_valid_reg)
        else $error("advanced item lost");

endmodule

// ===== src/lrl_cfg.sv =====
// configuration register file
module lrl_cfg (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            cfg_we,
    input  logic [lrl_pkg::CFG_INDEX_W-1:0] cfg_index,
    input  logic [lrl_pkg::CFG_DATA_W-1:0]  cfg_data,
    output lrl_pkg::cfg_t                   cfg
);
    import lrl_pkg::*;

    cfg_t cfg_reg;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            cfg_reg <= '0;
        end
        else if (cfg_we)
        begin
            case (cfg_index)
                CFG_WINDOW_THRESHOLD: cfg_reg.window_threshold <= cfg_data[STAMP_W-1:0];
                CFG_RESUME_GAP:       cfg_reg.resume_gap       <= cfg_data[STAMP_W-1:0];
                CFG_OUTPUT_DISABLED:  cfg_reg.output_disabled  <= cfg_data[0];
                CFG_SOURCE_TAG:       cfg_reg.source_tag       <= cfg_data[TAG_W-1:0];
                default:              cfg_reg                  <= cfg_reg;
            endcase
        end
    end

    assign cfg = cfg_reg;

endmodule

// ===== src/lrl_ring.sv =====
// timestamp ring with head, tail, fill count and last accepted stamp
module lrl_ring (
    input  logic                  clk,
    input  logic                  rst_n,
    input  lrl_pkg::ring_cmd_t    cmd,
    output lrl_pkg::ring_status_t status
);
    import lrl_pkg::*;

    localparam logic [RING_PTR_W-1:0] PTR_LAST = RING_PTR_W'(RING_DEPTH - 1);
    localparam logic [RING_CNT_W-1:0] CNT_FULL = RING_CNT_W'(RING_DEPTH);

    logic [STAMP_W-1:0]    stamp_ring_reg [RING_DEPTH];
    logic [STAMP_W-1:0]    last_stamp_reg;
    logic [RING_PTR_W-1:0] head_reg, head_next;
    logic [RING_PTR_W-1:0] tail_reg, tail_next;
    logic [RING_CNT_W-1:0] count_reg, count_next;

    logic [RING_PTR_W-1:0] head_base, tail_base;
    logic [RING_CNT_W-1:0] count_base;

    function automatic logic [RING_PTR_W-1:0] ptr_inc(input logic [RING_PTR_W-1:0] p);
        ptr_inc = (p == PTR_LAST) ? '0 : p + RING_PTR_W'(1);
    endfunction

    always_comb
    begin
        head_base  = cmd.clear ? '0 : head_reg;
        tail_base  = cmd.clear ? '0 : tail_reg;
        count_base = cmd.clear ? '0 : count_reg;
        head_next  = head_base;
        tail_next  = tail_base;
        count_next = count_base;
        if (cmd.push)
        begin
            tail_next = ptr_inc(tail_base);
            if (count_base == CNT_FULL)
                head_next = ptr_inc(head_base);
            else
                count_next = count_base + RING_CNT_W'(1);
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            head_reg  <= '0;
            tail_reg  <= '0;
            count_reg <= '0;
        end
        else
        begin
            head_reg  <= head_next;
            tail_reg  <= tail_next;
            count_reg <= count_next;
        end
    end

    // entries are not cleared, only written entries are ever used
    always_ff @(posedge clk)
    begin
        if (cmd.push)
        begin
            stamp_ring_reg[tail_base] <= cmd.stamp;
            last_stamp_reg            <= cmd.stamp;
        end
    end

    assign status.full   = (count_reg == CNT_FULL);
    assign status.oldest = stamp_ring_reg[head_reg];
    assign status.last   = (count_reg == '0) ? '0 : last_stamp_reg;

endmodule

// ===== src/lrl_limiter.sv =====
// suppression decision, skip counter and scaled time delta
module lrl_limiter (
    input  logic                            clk,
    input  logic                            rst_n,
    input  logic                            fire,
    input  logic [lrl_pkg::STAMP_W-1:0]     stamp,
    input  lrl_pkg::cfg_t                   cfg,
    input  lrl_pkg::ring_status_t           ring,
    output lrl_pkg::ring_cmd_t              ring_cmd,
    output lrl_pkg::result_t                result
);
    import lrl_pkg::*;

    logic [SKIP_W-1:0]   skip_reg, skip_next;
    logic [SCALED_W-1:0] last_scaled_reg, last_scaled_next;

    logic [STAMP_W-1:0]  gap, age;
    logic [SCALED_W-1:0] scaled;
    logic                skipping;

    assign gap      = stamp - ring.last;
    assign age      = stamp - ring.oldest;
    assign scaled   = stamp[STAMP_W-1:SCALE_SHIFT];
    assign skipping = (skip_reg != '0);

    always_comb
    begin
        result           = '0;
        result.verdict   = V_PASS;
        ring_cmd.push    = 1'b0;
        ring_cmd.clear   = 1'b0;
        ring_cmd.stamp   = stamp;
        skip_next        = skip_reg;
        last_scaled_next = last_scaled_reg;
        if (cfg.output_disabled)
        begin
            result.verdict = V_DISABLED;
        end
        else if (skipping && (gap <= cfg.resume_gap))
        begin
            result.verdict = V_SKIPPED;
            if (skip_reg != SKIP_MAX)
                skip_next = skip_reg + SKIP_W'(1);
        end
        // after a resume the ring holds only the resuming stamp, so it is not full for the next item
        else if (!skipping && ring.full && (age <= cfg.window_threshold))
        begin
            result.verdict = V_START;
            skip_next      = SKIP_W'(1);
        end
        else
        begin
            ring_cmd.push  = fire;
            ring_cmd.clear = fire && skipping;
            result.verdict = skipping ? V_RESUME : V_PASS;
            result.skipped_count = skip_reg;
            if (scaled > last_scaled_reg)
            begin
                result.delta_negative  = 1'b0;
                result.delta_magnitude = scaled - last_scaled_reg;
            end
            else
            begin
                result.delta_negative  = 1'b1;
                result.delta_magnitude = last_scaled_reg - scaled;
            end
            result.tag       = cfg.source_tag;
            skip_next        = '0;
            last_scaled_next = scaled;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            skip_reg        <= '0;
            last_scaled_reg <= '0;
        end
        else if (fire)
        begin
            skip_reg        <= skip_next;
            last_scaled_reg <= last_scaled_next;
        end
    end

endmodule
